/* sv/skt_pkg.sv */
// Package for the sorted key table: field widths, command and status codes,
// beat structs for the command and result channels, and cell control types.
// Depends on nothing; every other file of the block imports it.
package skt_pkg;

  localparam int KEY_W            = 37;
  localparam int PAY_IN_W         = 32;
  localparam int POS_W            = 7;
  localparam int CMD_W            = 3;
  localparam int STAT_W           = 3;
  localparam int KEY_DIGITS       = 11;
  localparam int CAPACITY_DEF     = 64;
  localparam int PAYLOAD_BITS_DEF = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_READ   = 3'd2,
    CMD_FIND   = 3'd3,
    CMD_UPDATE = 3'd4,
    CMD_CLEAR  = 3'd5
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_DUP      = 3'd1,
    STAT_FULL     = 3'd2,
    STAT_BADPOS   = 3'd3,
    STAT_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_APPLY
  } state_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE,
    OP_UPDATE
  } cell_op_t;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [KEY_W-1:0]    key_in;
    logic [PAY_IN_W-1:0] payload_in;
    logic [POS_W-1:0]    position_in;
  } cmd_in_t;

  typedef struct packed {
    logic [STAT_W-1:0]   status;
    logic [KEY_W-1:0]    key_out;
    logic [PAY_IN_W-1:0] payload_out;
    logic [POS_W-1:0]    position_out;
    logic [POS_W-1:0]    count_out;
  } result_t;

  // Per-cell compare results, captured when a command beat is accepted.
  typedef struct packed {
    logic valid;
    logic lt;
    logic eq;
    logic at;
    logic ge_pos;
  } cell_flags_t;

  typedef struct packed {
    cell_op_t         op;
    logic [KEY_W-1:0] key;
  } cell_ctrl_t;

endpackage

/* sv/skt_cell.sv */
// One slot of the sorted key table: holds a key and payload, compares its key
// and rank against the incoming command and shifts to or from its neighbors.
// Depends on skt_pkg.
module skt_cell #(
  parameter int PAYLOAD_BITS = skt_pkg::PAYLOAD_BITS_DEF,
  parameter int CW           = 7,
  parameter int INDEX        = 0
) (
  input  logic                      clk,
  input  logic                      capture,
  input  logic [skt_pkg::KEY_W-1:0] cmp_key,
  input  logic [skt_pkg::POS_W-1:0] cmp_pos,
  input  logic [CW-1:0]             count,
  input  logic                      apply,
  input  skt_pkg::cell_ctrl_t       ctrl,
  input  logic [PAYLOAD_BITS-1:0]   new_payload,
  input  logic                      left_lt,
  input  logic [skt_pkg::KEY_W-1:0] left_key,
  input  logic [PAYLOAD_BITS-1:0]   left_payload,
  input  logic [skt_pkg::KEY_W-1:0] right_key,
  input  logic [PAYLOAD_BITS-1:0]   right_payload,
  output logic [skt_pkg::KEY_W-1:0] key,
  output logic [PAYLOAD_BITS-1:0]   payload,
  output skt_pkg::cell_flags_t      flags
);
  import skt_pkg::*;

  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CMPW-1:0] RANK = CMPW'(INDEX + 1);

  logic here_valid;

  assign here_valid = (CMPW'(count) >= RANK);

  always_ff @(posedge clk) begin
    if (capture) begin
      flags.valid  <= here_valid;
      flags.lt     <= here_valid && (key < cmp_key);
      flags.eq     <= here_valid && (key == cmp_key);
      flags.at     <= (CMPW'(cmp_pos) == RANK);
      flags.ge_pos <= (RANK >= CMPW'(cmp_pos));
    end
    if (apply) begin
      case (ctrl.op)
        OP_INSERT: begin
          // Cells below the insert point keep their entry; the boundary cell
          // takes the new one and every cell above takes its left neighbor.
          if (!flags.lt) begin
            if (left_lt) begin
              key     <= ctrl.key;
              payload <= new_payload;
            end else begin
              key     <= left_key;
              payload <= left_payload;
            end
          end
        end
        OP_REMOVE: begin
          if (flags.ge_pos) begin
            key     <= right_key;
            payload <= right_payload;
          end
        end
        OP_UPDATE: begin
          if (flags.eq) begin
            payload <= new_payload;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* sv/sorted_key_table_core.sv */
// Top level of the sorted key table: command sequencer, result selection and
// the row of skt_cell slots that hold the entries in ascending key order.
// Depends on skt_pkg and skt_cell.
//
// Usage:
//   A command beat is taken at a rising edge with start high and busy low.
//   The cells compare the command key and position at that edge; in the next
//   cycle (busy high) the row shifts or updates in one step and the result is
//   registered. The result beat appears on result with done high for exactly
//   one cycle, the cycle after busy, and start may be taken in that same
//   cycle. A command therefore passes the compare step and then the
//   shift-and-select step of the cell row before its result is shown, and a
//   new command is not taken while busy is high.
//   The receiver cannot stall: a result beat is shown once and is gone.
//   Reset (rst, synchronous) empties the table by clearing the entry count;
//   the key and payload slots are not cleared and need no clearing pass.
//   Entries at or above the count are never reported.
module sorted_key_table_core #(
  parameter int CAPACITY     = skt_pkg::CAPACITY_DEF,
  parameter int PAYLOAD_BITS = skt_pkg::PAYLOAD_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  skt_pkg::cmd_in_t request,
  output logic             done,
  output skt_pkg::result_t result
);
  import skt_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  state_t state, state_next;
  cmd_in_t req_q;
  logic [CW-1:0] count, count_next;
  result_t result_next;
  logic capture, apply;
  cell_ctrl_t ctrl;
  logic [PAYLOAD_BITS-1:0] new_payload;

  logic [KEY_W-1:0]        cell_key     [CAPACITY];
  logic [PAYLOAD_BITS-1:0] cell_pay     [CAPACITY];
  cell_flags_t             cell_flg     [CAPACITY];
  logic                    left_lt      [CAPACITY];
  logic [KEY_W-1:0]        left_key     [CAPACITY];
  logic [PAYLOAD_BITS-1:0] left_pay     [CAPACITY];
  logic [KEY_W-1:0]        right_key    [CAPACITY];
  logic [PAYLOAD_BITS-1:0] right_pay    [CAPACITY];

  logic                    any_eq, any_at;
  logic [KEY_W-1:0]        eq_key, at_key;
  logic [PAYLOAD_BITS-1:0] eq_pay, at_pay;
  logic [CW-1:0]           eq_rank, ins_rank;

  assign capture     = start && !busy;
  assign apply       = (state == ST_APPLY);
  assign busy        = (state == ST_APPLY);
  assign new_payload = PAYLOAD_BITS'(req_q.payload_in);

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      if (gi == 0) begin : g_first
        assign left_lt[gi]  = 1'b1;
        assign left_key[gi] = '0;
        assign left_pay[gi] = '0;
      end else begin : g_mid
        assign left_lt[gi]  = cell_flg[gi-1].lt;
        assign left_key[gi] = cell_key[gi-1];
        assign left_pay[gi] = cell_pay[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
        assign right_key[gi] = '0;
        assign right_pay[gi] = '0;
      end else begin : g_inner
        assign right_key[gi] = cell_key[gi+1];
        assign right_pay[gi] = cell_pay[gi+1];
      end

      skt_cell #(
        .PAYLOAD_BITS(PAYLOAD_BITS),
        .CW          (CW),
        .INDEX       (gi)
      ) u_cell (
        .clk          (clk),
        .capture      (capture),
        .cmp_key      (request.key_in),
        .cmp_pos      (request.position_in),
        .count        (count),
        .apply        (apply),
        .ctrl         (ctrl),
        .new_payload  (new_payload),
        .left_lt      (left_lt[gi]),
        .left_key     (left_key[gi]),
        .left_payload (left_pay[gi]),
        .right_key    (right_key[gi]),
        .right_payload(right_pay[gi]),
        .key          (cell_key[gi]),
        .payload      (cell_pay[gi]),
        .flags        (cell_flg[gi])
      );
    end
  endgenerate

  // At most one cell matches by key and at most one by position, so the
  // selections are plain AND-OR trees across the row.
  always_comb begin
    any_eq   = 1'b0;
    any_at   = 1'b0;
    eq_key   = '0;
    at_key   = '0;
    eq_pay   = '0;
    at_pay   = '0;
    eq_rank  = '0;
    ins_rank = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (cell_flg[i].eq) begin
        any_eq  = 1'b1;
        eq_key  = eq_key | cell_key[i];
        eq_pay  = eq_pay | cell_pay[i];
        eq_rank = eq_rank | CW'(i + 1);
      end
      if (cell_flg[i].at && cell_flg[i].valid) begin
        any_at = 1'b1;
        at_key = at_key | cell_key[i];
        at_pay = at_pay | cell_pay[i];
      end
      if (!cell_flg[i].lt && left_lt[i]) begin
        ins_rank = ins_rank | CW'(i + 1);
      end
    end
  end

  always_comb begin
    state_next  = state;
    count_next  = count;
    ctrl.op     = OP_HOLD;
    ctrl.key    = req_q.key_in;
    result_next = '0;
    case (state)
      ST_IDLE: begin
        if (capture) begin
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: begin
        state_next = ST_IDLE;
        case (cmd_t'(req_q.command))
          CMD_INSERT: begin
            if (any_eq) begin
              result_next.status       = STAT_DUP;
              result_next.key_out      = eq_key;
              result_next.payload_out  = PAY_IN_W'(eq_pay);
              result_next.position_out = POS_W'(eq_rank);
            end else if (32'(count) >= CAPACITY) begin
              result_next.status = STAT_FULL;
            end else begin
              ctrl.op                  = OP_INSERT;
              count_next               = CW'(count + 1'b1);
              result_next.status       = STAT_OK;
              result_next.key_out      = req_q.key_in;
              result_next.payload_out  = PAY_IN_W'(new_payload);
              result_next.position_out = POS_W'(ins_rank);
            end
          end
          CMD_REMOVE, CMD_READ: begin
            if (any_at) begin
              if (cmd_t'(req_q.command) == CMD_REMOVE) begin
                ctrl.op    = OP_REMOVE;
                count_next = CW'(count - 1'b1);
              end
              result_next.status       = STAT_OK;
              result_next.key_out      = at_key;
              result_next.payload_out  = PAY_IN_W'(at_pay);
              result_next.position_out = req_q.position_in;
            end else begin
              result_next.status = STAT_BADPOS;
            end
          end
          CMD_FIND, CMD_UPDATE: begin
            if (count == '0) begin
              result_next.status = STAT_BADPOS;
            end else if (any_eq) begin
              result_next.status       = STAT_OK;
              result_next.key_out      = eq_key;
              result_next.position_out = POS_W'(eq_rank);
              if (cmd_t'(req_q.command) == CMD_UPDATE) begin
                ctrl.op                 = OP_UPDATE;
                result_next.payload_out = PAY_IN_W'(new_payload);
              end else begin
                result_next.payload_out = PAY_IN_W'(eq_pay);
              end
            end else begin
              result_next.status = STAT_NOTFOUND;
            end
          end
          CMD_CLEAR: begin
            count_next         = '0;
            result_next.status = STAT_OK;
          end
          default: begin
            result_next.status = STAT_OK;
          end
        endcase
        result_next.count_out = POS_W'(count_next);
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= apply;
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      req_q <= request;
    end
    if (apply) begin
      result <= result_next;
    end
  end

endmodule

/* sv/skt_checker.sv */
// Port-level checks for sorted_key_table_core: command/result timing and
// consistency of result beats, bound to the top level below.
// Depends on skt_pkg and sorted_key_table_core.
module skt_checker #(
  parameter int CAPACITY = skt_pkg::CAPACITY_DEF
) (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input skt_pkg::result_t result
);
  import skt_pkg::*;

  // An accepted command raises busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  // Every busy cycle is followed by a result beat with busy low.
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> (done && !busy))
    else $error("busy cycle not followed by a result beat");

  // A result beat only follows a busy cycle.
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result beat without a command in flight");

  // Failed commands report no entry.
  a_fail_empty: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == STAT_FULL || result.status == STAT_BADPOS ||
              result.status == STAT_NOTFOUND))
    |-> (result.key_out == '0 && result.payload_out == '0 &&
         result.position_out == '0))
    else $error("failed command reported an entry");

  // The reported count never exceeds the capacity.
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    done |-> (32'(result.count_out) <= CAPACITY))
    else $error("entry count above capacity");

endmodule

bind sorted_key_table_core skt_checker #(.CAPACITY(CAPACITY)) u_skt_checker (.*);
